@@ rtl/core/spearman_rank_correlation_assert.svh @@
// assertion macros for the spearman rank correlation block
// used by spearman_rank_correlation in rtl/core, no other dependency
`ifndef SPEARMAN_RANK_CORRELATION_ASSERT_SVH
`define SPEARMAN_RANK_CORRELATION_ASSERT_SVH
`define SRC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define SRC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`endif

@@ rtl/core/src_pkg.sv @@
// types and constants for the spearman rank correlation block
// no dependencies
package src_pkg;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFew = 2'd1;
  localparam logic [1:0] StatusOvf = 2'd2;
  localparam int unsigned RhoOne = 16384;
  localparam int unsigned RhoScale = 24576;

  typedef struct packed {
    logic [15:0] score_a;
    logic [15:0] score_b;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rho_q14;
    logic [12:0]        sum_sq_diff_x4;
    logic [1:0]         status;
  } out_item_t;
endpackage

@@ rtl/core/src_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module src_div #(
  parameter int unsigned W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] rem_q, quo_q, den_q;
  logic [CW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [W:0] trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

@@ rtl/core/spearman_rank_correlation.sv @@
// top level of the spearman rank correlation block
// depends on src_pkg, src_div and spearman_rank_correlation_assert.svh
//
// One pair of scores is taken per item when start is high and busy low.
// Pairs are stored in a score memory until an item with last set arrives;
// that item starts evaluation and busy stays high until the result.
// Loading takes one cycle per pair. Evaluation walks every pair i against
// every pair j through the memory read port, then a 48-step serial divider
// forms the rho term before the result strobe. Fewer than two pairs skip
// the walk and the divider. Pairs beyond MAX_PAIRS are dropped and flagged.
// The result is on result_o for one cycle with valid_o high; the receiver
// cannot stall, so no buffering is needed. Reset empties the store and
// clears the counters; the memory itself needs no clearing.
module spearman_rank_correlation #(
  parameter int unsigned MAX_PAIRS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  src_pkg::in_item_t     item_i,
  output logic                  valid_o,
  output src_pkg::out_item_t    result_o
);
  `include "spearman_rank_correlation_assert.svh"
  localparam int unsigned AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned RW = CW + 2;
  localparam int unsigned SW = 2 * RW + CW;
  localparam int unsigned NW = 2 * CW;
  localparam int unsigned DDW = 3 * CW;
  localparam int unsigned DW = 48;

  typedef enum logic [2:0] {
    StLoad, StScan, StAcc, StDiv, StDone
  } state_e;

  state_e state_q;
  logic [15:0] mem_a [MAX_PAIRS];
  logic [15:0] mem_b [MAX_PAIRS];
  logic [15:0] rda_q, rdb_q, cur_a_q, cur_b_q;
  logic [CW-1:0] cnt_q, i_q, j_q;
  logic ovf_q, rd_ok_q, rd_first_q, acc_q;
  logic [RW-1:0] la_q, sa_q, lb_q, sb_q;
  logic [SW-1:0] s4_q;
  logic [RW-1:0] ra, rb, dif;
  logic [NW-1:0] nsq;
  logic [DDW-1:0] dd;
  logic [DW-1:0] num, den, quo;
  logic div_start, div_done;
  logic [CW-1:0] rd_idx;
  logic accept;
  logic [15:0] xs;

  assign accept = start && !busy;
  assign busy = (state_q != StLoad);

  always_comb begin
    rd_idx = j_q;
    if (j_q == cnt_q) rd_idx = rd_ok_q ? i_q + 1'b1 : i_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q < CW'(MAX_PAIRS)) begin
      mem_a[cnt_q[AW-1:0]] <= item_i.score_a;
      mem_b[cnt_q[AW-1:0]] <= item_i.score_b;
    end
    rda_q <= mem_a[rd_idx[AW-1:0]];
    rdb_q <= mem_b[rd_idx[AW-1:0]];
  end

  assign ra = (la_q << 1) + sa_q + RW'(1);
  assign rb = (lb_q << 1) + sb_q + RW'(1);
  assign dif = (ra > rb) ? ra - rb : rb - ra;
  assign nsq = NW'(cnt_q) * NW'(cnt_q);
  assign dd = DDW'(nsq - NW'(1)) * DDW'(cnt_q);
  // 2 * rho scale is 3 << 14
  assign num = (DW'(s4_q) << 15) + (DW'(s4_q) << 14) + DW'(dd);
  assign den = DW'({dd, 1'b0});
  assign div_start = (state_q == StAcc) && (i_q == cnt_q) && !acc_q;
  assign xs = (quo > DW'(32768)) ? 16'd32768 : quo[15:0];

  src_div #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      rd_ok_q <= 1'b0;
      rd_first_q <= 1'b0;
      acc_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      case (state_q)
        StLoad: begin
          if (accept) begin
            if (cnt_q < CW'(MAX_PAIRS)) cnt_q <= cnt_q + 1'b1;
            else ovf_q <= 1'b1;
            if (item_i.last) begin
              i_q <= '0;
              j_q <= CW'(MAX_PAIRS);
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          j_q <= cnt_q;
          rd_ok_q <= 1'b0;
          rd_first_q <= 1'b0;
          acc_q <= 1'b0;
          if (cnt_q < CW'(2)) begin
            state_q <= StDone;
          end else begin
            state_q <= StAcc;
          end
        end
        StAcc: begin
          if (i_q != cnt_q) begin
            rd_first_q <= (j_q == cnt_q);
            rd_ok_q <= (j_q != cnt_q);
            acc_q <= rd_ok_q && (j_q == cnt_q);
            if (j_q == cnt_q) j_q <= '0;
            else j_q <= j_q + 1'b1;
            if (rd_ok_q && j_q == cnt_q) i_q <= i_q + 1'b1;
          end else begin
            acc_q <= 1'b0;
            if (!acc_q) state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) state_q <= StDone;
        end
        StDone: begin
          valid_o <= 1'b1;
          cnt_q <= '0;
          ovf_q <= 1'b0;
          state_q <= StLoad;
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StScan) s4_q <= '0;
    if (state_q == StAcc && acc_q) s4_q <= s4_q + SW'(dif * dif);
    if (state_q == StAcc && i_q != cnt_q) begin
      if (rd_first_q) begin
        cur_a_q <= rda_q;
        cur_b_q <= rdb_q;
        la_q <= '0; sa_q <= '0; lb_q <= '0; sb_q <= '0;
      end else if (rd_ok_q) begin
        if (rda_q < cur_a_q) la_q <= la_q + 1'b1;
        else if (rda_q == cur_a_q) sa_q <= sa_q + 1'b1;
        if (rdb_q < cur_b_q) lb_q <= lb_q + 1'b1;
        else if (rdb_q == cur_b_q) sb_q <= sb_q + 1'b1;
      end
    end
    if (state_q == StDone) begin
      if (cnt_q < CW'(2)) begin
        result_o.rho_q14 <= '0;
        result_o.sum_sq_diff_x4 <= '0;
        result_o.status <= src_pkg::StatusFew;
      end else begin
        result_o.rho_q14 <= 16'(src_pkg::RhoOne) - xs;
        result_o.sum_sq_diff_x4 <= 13'(s4_q);
        result_o.status <= ovf_q ? src_pkg::StatusOvf : src_pkg::StatusOk;
      end
    end
  end

  `SRC_ASSERT(a_busy_no_accept, clk_i, rst_ni, valid_o |-> !$past(accept))
  `SRC_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CW'(MAX_PAIRS))
  `SRC_ASSERT(a_done_valid, clk_i, rst_ni, (state_q == StDone) |=> valid_o)
endmodule

@@ verif/tb.sv @@
// testbench for spearman_rank_correlation: directed and random score sets
// depends on src_pkg and the rtl top level; predicts rho, sum and status per set
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 16;
  localparam int unsigned STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  src_pkg::in_item_t item_i = '0;
  logic valid_o;
  src_pkg::out_item_t result_o;

  logic [15:0] set_a[CAP];
  logic [15:0] set_b[CAP];
  int unsigned stored_pairs = 0;
  bit set_overflow = 1'b0;
  src_pkg::out_item_t expected_rho_q[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned gap_pct = 0;

  spearman_rank_correlation #(.MAX_PAIRS(CAP)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .valid_o(valid_o), .result_o(result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned twice_rank(input logic [15:0] s[CAP], input int n,
                                                 input int i);
    longint unsigned lt, eq;
    lt = 0;
    eq = 0;
    for (int j = 0; j < n; j++) begin
      if (s[j] < s[i]) lt++;
      else if (s[j] == s[i]) eq++;
    end
    return 2 * lt + eq + 1;
  endfunction

  function automatic src_pkg::out_item_t rank_corr_of_set();
    src_pkg::out_item_t r;
    longint unsigned s4, d, x, ra, rb, df;
    int n;
    n = stored_pairs;
    s4 = 0;
    if (n < 2) begin
      r.rho_q14 = '0;
      r.sum_sq_diff_x4 = '0;
      r.status = src_pkg::StatusFew;
    end else begin
      for (int i = 0; i < n; i++) begin
        ra = twice_rank(set_a, n, i);
        rb = twice_rank(set_b, n, i);
        df = ra > rb ? ra - rb : rb - ra;
        s4 += df * df;
      end
      d = n * (n * n - 1);
      x = (2 * (src_pkg::RhoScale * s4) + d) / (2 * d);
      if (x > 32768) x = 32768;
      r.rho_q14 = 16'(longint'(src_pkg::RhoOne) - longint'(x));
      r.sum_sq_diff_x4 = s4[12:0];
      r.status = set_overflow ? src_pkg::StatusOvf : src_pkg::StatusOk;
    end
    return r;
  endfunction

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input bit fin);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{score_a: a, score_b: b, last: fin};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (stored_pairs < CAP) begin
      set_a[stored_pairs] = a;
      set_b[stored_pairs] = b;
      stored_pairs++;
    end else begin
      set_overflow = 1'b1;
    end
    if (fin) begin
      expected_rho_q.push_back(rank_corr_of_set());
      stored_pairs = 0;
      set_overflow = 1'b0;
    end
  endtask

  function automatic logic [15:0] rand_score(input int mode);
    case (mode)
      0: return 16'($urandom_range(3));
      1: return 16'($urandom);
      default: return $urandom_range(1) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  task automatic send_set(input int n, input int mode);
    for (int i = 0; i < n; i++)
      send_pair(rand_score(mode), rand_score(mode), i == n - 1);
  endtask

  task automatic test_directed();
    send_pair(16'h0000, 16'hffff, 1'b1);
    for (int i = 0; i < 4; i++) send_pair(16'(i), 16'(i), i == 3);
    for (int i = 0; i < 4; i++) send_pair(16'(i), 16'(3 - i), i == 3);
    for (int i = 0; i < 3; i++) send_pair(16'h7777, 16'(i), i == 2);
    for (int i = 0; i < 2; i++) send_pair(16'(i), 16'hffff - 16'(i), i == 1);
    for (int i = 0; i < 18; i++) send_pair(16'(i * 4099), 16'(17 - i) * 3, i == 17);
  endtask

  task automatic test_random(input int sets);
    for (int k = 0; k < sets; k++) begin
      if ($urandom_range(9) == 0) send_set($urandom_range(19, 16), $urandom_range(2));
      else send_set($urandom_range(8, 1), $urandom_range(2));
    end
  endtask

  always @(posedge clk_i) begin
    if (valid_o) begin
      results_seen++;
      if (expected_rho_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        src_pkg::out_item_t e;
        e = expected_rho_q.pop_front();
        if (result_o.rho_q14 !== e.rho_q14) begin
          $error("rho_q14 exp %0d got %0d", e.rho_q14, result_o.rho_q14);
          errors++;
        end
        if (result_o.sum_sq_diff_x4 !== e.sum_sq_diff_x4) begin
          $error("sum_sq_diff_x4 exp %0d got %0d", e.sum_sq_diff_x4,
                 result_o.sum_sq_diff_x4);
          errors++;
        end
        if (result_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (valid_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL spearman_rank_correlation");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 6;
    test_directed();
    test_random(30);
    gap_pct = 88;
    test_random(20);
    gap_pct = 0;
    test_random(30);
    start <= 1'b0;
    while (expected_rho_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("covered %0d pairs in %0d sets: ties, extremes, short and overflowing sets",
             items_sent, results_seen);
    if (errors == 0) $display("PASS spearman_rank_correlation");
    else $display("FAIL spearman_rank_correlation");
    $finish;
  end
endmodule
